// ----- hw/rtl/wrms_pkg.sv -----
// Shared constants and types for the windowed RMS meter.
// No dependencies; used by every module of the block.
`default_nettype none

package wrms_pkg;

    // Fixed field widths
    localparam int unsigned SAMPLE_W       = 16;
    localparam int unsigned CFG_W          = 11;
    localparam int unsigned RMS_W          = 16;

    // Register reset value and default ring depth
    localparam int unsigned CFG_RESET      = 1024;
    localparam int unsigned MAX_WINDOW_DEF = 1024;

    // Square of a sample needs 2*SAMPLE_W-1 bits; the root unit works on 2*SAMPLE_W.
    localparam int unsigned SQ_W           = 2 * SAMPLE_W - 1;
    localparam int unsigned RAD_W          = 2 * SAMPLE_W;

    // Job queue between front and back
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QLVL_W         = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              not_empty;
        logic [QLVL_W-1:0] level;
    } q_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wrms_front.sv -----
// Front end: sample ring, running sum of squares, emission counter, interval register.
// Depends on wrms_pkg.
`default_nettype none

module wrms_front #(
    parameter int unsigned MAX_WINDOW = wrms_pkg::MAX_WINDOW_DEF,
    parameter int unsigned SUM_W      = wrms_pkg::SQ_W + $clog2(MAX_WINDOW + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [wrms_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                          cfg_wr_en,
    input  wire logic [wrms_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire wrms_pkg::q_stat_t             q_stat,
    output logic                               push,
    output logic [SUM_W-1:0]                   push_sum,
    output logic [wrms_pkg::CFG_W-1:0]         interval
);

    localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
    localparam int unsigned CFG_W = wrms_pkg::CFG_W;
    localparam int unsigned SW    = wrms_pkg::SAMPLE_W;
    localparam int unsigned SQ_W  = wrms_pkg::SQ_W;
    localparam logic [CFG_W-1:0] N_RESET = (wrms_pkg::CFG_RESET > MAX_WINDOW) ?
        CFG_W'(MAX_WINDOW) : CFG_W'(wrms_pkg::CFG_RESET);

    function automatic logic [CFG_W-1:0] clamp_interval(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (32'(v) > MAX_WINDOW) begin
            r = CFG_W'(MAX_WINDOW);
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [SW-1:0]    ring [MAX_WINDOW];

    logic [CFG_W-1:0] n_reg;
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic             wrapped_reg, wrapped_next;
    logic [CFG_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    // stage A: ring read, new sample held
    logic             va_reg, emit_a_reg, old_ok_a_reg;
    logic [SW-1:0]    new_a_reg, old_a_reg;
    // stage B: squares
    logic             vb_reg, emit_b_reg;
    logic [SQ_W-1:0]  sq_new_reg, sq_old_reg;

    logic                   acc, emit;
    logic [CFG_W:0]         cnt_inc;
    logic signed [2*SW-1:0] prod_new, prod_old;

    assign acc = s_tvalid && s_tready;

    // room in the queue for every emission still in the pipe plus one more
    always_comb begin
        s_tready = (32'(q_stat.level) + 32'(emit_a_reg) + 32'(emit_b_reg))
                   < wrms_pkg::QUEUE_DEPTH;
    end

    always_comb begin
        cnt_inc = {1'b0, cnt_reg} + (CFG_W + 1)'(1);
        emit    = cnt_inc > {1'b0, n_reg};
        cnt_next = emit ? '0 : cnt_inc[CFG_W-1:0];
        if ((32'(widx_reg) + 32'd1) >= 32'(n_reg)) begin
            widx_next    = '0;
            wrapped_next = 1'b1;
        end else begin
            widx_next    = widx_reg + IDX_W'(1);
            wrapped_next = wrapped_reg;
        end
    end

    // read-first ring: the old sample comes out at the edge the new one goes in
    always_ff @(posedge aclk) begin
        if (acc) begin
            old_a_reg      <= ring[widx_reg];
            ring[widx_reg] <= sample;
        end
    end

    always_comb begin
        prod_new = $signed(new_a_reg) * $signed(new_a_reg);
        prod_old = $signed(old_a_reg) * $signed(old_a_reg);
        sum_next = sum_reg + SUM_W'(sq_new_reg) - SUM_W'(sq_old_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= N_RESET;
            widx_reg    <= '0;
            wrapped_reg <= 1'b0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            va_reg      <= 1'b0;
            emit_a_reg  <= 1'b0;
            vb_reg      <= 1'b0;
            emit_b_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            // new interval: window restarts empty
            n_reg       <= clamp_interval(cfg_wr_data);
            widx_reg    <= '0;
            wrapped_reg <= 1'b0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            va_reg      <= 1'b0;
            emit_a_reg  <= 1'b0;
            vb_reg      <= 1'b0;
            emit_b_reg  <= 1'b0;
        end else begin
            va_reg     <= acc;
            emit_a_reg <= acc && emit;
            vb_reg     <= va_reg;
            emit_b_reg <= emit_a_reg;
            if (acc) begin
                widx_reg    <= widx_next;
                wrapped_reg <= wrapped_next;
                cnt_reg     <= cnt_next;
            end
            if (vb_reg) begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            new_a_reg    <= sample;
            old_ok_a_reg <= wrapped_reg;  // slot unwritten since clear reads as zero
        end
        if (va_reg) begin
            sq_new_reg <= prod_new[SQ_W-1:0];
            sq_old_reg <= old_ok_a_reg ? prod_old[SQ_W-1:0] : '0;
        end
    end

    assign push     = vb_reg && emit_b_reg;
    assign push_sum = sum_next;
    assign interval = n_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/wrms_queue.sv -----
// Short job queue carrying sum snapshots from the front end to the root unit.
// Depends on wrms_pkg.
`default_nettype none

module wrms_queue #(
    parameter int unsigned DATA_W = 42
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      head,
    output wrms_pkg::q_stat_t      q_stat
);

    localparam int unsigned DEPTH = wrms_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned LVL_W = wrms_pkg::QLVL_W;

    logic [DATA_W-1:0] slot [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0]  level_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({push, pop})
                2'b10:   level_reg <= level_reg + LVL_W'(1);
                2'b01:   level_reg <= level_reg - LVL_W'(1);
                default: level_reg <= level_reg;
            endcase
        end
    end

    assign head             = slot[rd_ptr_reg];
    assign q_stat.not_empty = level_reg != '0;
    assign q_stat.level     = level_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/wrms_back.sv -----
// Back end: bit-serial divide by the interval, bit-pair square root, output register.
// Depends on wrms_pkg.
`default_nettype none

module wrms_back #(
    parameter int unsigned SUM_W = 42
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire wrms_pkg::q_stat_t          q_stat,
    input  wire logic [SUM_W-1:0]           head,
    input  wire logic [wrms_pkg::CFG_W-1:0] interval,
    output logic                            pop,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [wrms_pkg::RMS_W-1:0]      m_tdata
);

    localparam int unsigned CFG_W = wrms_pkg::CFG_W;
    localparam int unsigned RAD_W = wrms_pkg::RAD_W;
    localparam int unsigned RMS_W = wrms_pkg::RMS_W;
    localparam int unsigned CNT_W = $clog2(SUM_W + 1);

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_DIV  = 4'b0010,
        BK_SQRT = 4'b0100,
        BK_DONE = 4'b1000
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] dcnt_reg;
    logic [CFG_W-1:0] rem_reg;
    logic [SUM_W-1:0] quot_reg;
    logic [RAD_W-1:0] x_reg, r_reg, bit_reg;
    logic             m_tvalid_reg;
    logic [RMS_W-1:0] m_tdata_reg;

    logic [CFG_W:0]   trial, trial_sub;
    logic             d_ge;
    logic [CFG_W-1:0] rem_next;
    logic [SUM_W-1:0] quot_next;
    logic [RAD_W:0]   s_t;
    logic             s_ge;
    logic [RAD_W-1:0] x_next, r_next;
    logic             load_out;

    always_comb begin
        trial     = {rem_reg, quot_reg[SUM_W-1]};
        trial_sub = trial - {1'b0, interval};
        d_ge      = trial >= {1'b0, interval};
        rem_next  = d_ge ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
        quot_next = {quot_reg[SUM_W-2:0], d_ge};

        s_t    = {1'b0, r_reg} + {1'b0, bit_reg};
        s_ge   = {1'b0, x_reg} >= s_t;
        x_next = s_ge ? RAD_W'({1'b0, x_reg} - s_t) : x_reg;
        r_next = s_ge ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_stat.not_empty) begin
                    pop        = 1'b1;
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (dcnt_reg == CNT_W'(1)) begin
                    state_next = BK_SQRT;
                end
            end
            BK_SQRT: begin
                if (bit_reg[0]) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                quot_reg <= head;
                rem_reg  <= '0;
                dcnt_reg <= CNT_W'(SUM_W);
            end
            BK_DIV: begin
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
                dcnt_reg <= dcnt_reg - CNT_W'(1);
                // mean fits the root unit's radicand
                x_reg    <= quot_next[RAD_W-1:0];
                r_reg    <= '0;
                bit_reg  <= RAD_W'(1) << (RAD_W - 2);
            end
            BK_SQRT: begin
                x_reg   <= x_next;
                r_reg   <= r_next;
                bit_reg <= bit_reg >> 2;
            end
            default: begin
            end
        endcase
        if (load_out) begin
            m_tdata_reg <= r_reg[RMS_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/windowed_rms_meter.sv -----
// Windowed RMS meter: one Q1.15 sample per cycle while s_tready, one RMS out per N+1 samples.
// From the sample beat that closes a window to m_tvalid: stages A and B post the sum, the
// back end picks up the job, divides over the SUM_W sum bits (42 at the default window),
// takes the root and loads the output register. Throughput: one sample per cycle while
// s_tready is high; the 4-entry queue fills and stalls s_tready when results come faster.
// Reset (aresetn, sync, low) empties the window, sets the interval to 1024; s_tready at once.
`default_nettype none

module windowed_rms_meter #(
    parameter int unsigned MAX_WINDOW = wrms_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input sample beats
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [wrms_pkg::SAMPLE_W-1:0] s_tdata,      // [15:0] sample
    // result beats
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [wrms_pkg::RMS_W-1:0]         m_tdata,      // [15:0] rms_value
    // interval_samples register
    input  wire logic                          cfg_wr_en,
    input  wire logic [wrms_pkg::CFG_W-1:0]    cfg_wr_data
);

    // sum of squares width: one square plus enough headroom for a full window
    localparam int unsigned SUM_W = wrms_pkg::SQ_W + $clog2(MAX_WINDOW + 1);

    wrms_pkg::q_stat_t           q_stat;
    logic                        push, pop;
    logic [SUM_W-1:0]            push_sum, head;
    logic [wrms_pkg::CFG_W-1:0]  interval;

    // Front end: ring read-modify-write at the accept edge, squares, then the running sum.
    // Every N+1 samples it posts a sum snapshot into the job queue.
    wrms_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .SUM_W      (SUM_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .sample      (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .push        (push),
        .push_sum    (push_sum),
        .interval    (interval)
    );

    // Decouples the sample stream from the slow divide/root unit.
    wrms_queue #(
        .DATA_W (SUM_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_sum),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // Back end: floor(sum / N) one quotient bit a cycle, then floor(sqrt) one root bit a
    // cycle, into an output register that can hold a result while the next one is worked on.
    wrms_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .head     (head),
        .interval (interval),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Credit logic must never let a snapshot land in a full queue.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_stat.level < wrms_pkg::QUEUE_DEPTH))
        else $error("job pushed into a full queue");

    // The back end only takes a job that is really there.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_stat.not_empty)
        else $error("job popped from an empty queue");

    // A push without a pop raises the queue level by exactly one.
    a_level_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (q_stat.level == $past(q_stat.level) + 1'b1))
        else $error("queue level out of step with pushes");

endmodule

`default_nettype wire
